### src/rlmf_pkg.sv
// Shared types, codes and the party palette for the RGB lamp controller.
package rlmf_pkg;

  localparam logic [1:0] KIND_KNOB   = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_BUTTON = 2'd2;

  localparam logic [1:0] MODE_KNOB  = 2'd0;
  localparam logic [1:0] MODE_RED   = 2'd1;
  localparam logic [1:0] MODE_PARTY = 2'd2;

  localparam logic [7:0] FULL_LEVEL_RST = 8'd250;

  localparam logic [7:0] HUE_RED_LO   = 8'd5;
  localparam logic [7:0] HUE_GREEN_LO = 8'd85;
  localparam logic [7:0] HUE_BLUE_LO  = 8'd170;
  localparam logic [7:0] HUE_RED_HI   = 8'd250;
  localparam logic [1:0] HUE_SLOPE    = 2'd3;

  localparam int unsigned PAL_IDX_W = 5;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] hue_sample;
    logic [7:0] brightness_sample;
    logic       red_button;
    logic       party_button;
  } item_t;

  typedef struct packed {
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;
    logic [7:0] brightness;
    logic [1:0] mode;
  } result_t;

  function automatic logic [23:0] palette_color(input logic [PAL_IDX_W-1:0] idx);
    logic [23:0] c;
    unique case (idx)
      5'd0:  c = 24'hFF0000;
      5'd1:  c = 24'hE80C7A;
      5'd2:  c = 24'hFD0DFF;
      5'd3:  c = 24'hA700E8;
      5'd4:  c = 24'h7200FF;
      5'd5:  c = 24'h320CE8;
      5'd6:  c = 24'h0D24FF;
      5'd7:  c = 24'h0053E8;
      5'd8:  c = 24'h009FFF;
      5'd9:  c = 24'h0CCFE8;
      5'd10: c = 24'h0CCFE8;
      5'd11: c = 24'h0DFFD8;
      5'd12: c = 24'h00E881;
      5'd13: c = 24'h00FF46;
      5'd14: c = 24'h0EE80C;
      5'd15: c = 24'h64FF0D;
      5'd16: c = 24'hA4E800;
      5'd17: c = 24'hFFFB00;
      5'd18: c = 24'hE8CE0C;
      5'd19: c = 24'hFFCA0D;
      5'd20: c = 24'hE89E00;
      5'd21: c = 24'hFF9300;
      5'd22: c = 24'hE86B0C;
      5'd23: c = 24'hFF520D;
      5'd24: c = 24'hE82201;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] step_toward(input logic [7:0] cur, input logic [7:0] tgt);
    logic [7:0] r;
    priority if (cur < tgt) r = cur + 8'd1;
    else if (cur > tgt)     r = cur - 8'd1;
    else                    r = cur;
    return r;
  endfunction

endpackage

### src/rlmf_in_stage.sv
// Input register stage: captures one beat and holds it until the core takes it.
module rlmf_in_stage import rlmf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t item_i,
  input  logic  take_i,
  output logic  in_stall_o,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      item_d  = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### src/rlmf_core.sv
// Lamp state registers with colour wheel, palette fade and button mode logic.
module rlmf_core import rlmf_pkg::*; #(
  parameter int unsigned NUM_COLOURS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  item_t      item_i,
  input  logic [7:0] full_level_i,
  output result_t    result_o
);

  logic [1:0]           mode_q, mode_d;
  logic [7:0]           red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [7:0]           bright_q, bright_d;
  logic [PAL_IDX_W-1:0] idx_q, idx_d;
  logic                 red_held_q, red_held_d, party_held_q, party_held_d;

  logic [7:0]           h, off, wheel_lvl;
  logic [9:0]           prod;
  logic [23:0]          target;
  logic [7:0]           step_r, step_g, step_b;
  logic [PAL_IDX_W:0]   idx_inc;
  logic                 red_on, party_on;

  always_comb begin
    h = item_i.hue_sample;
    priority if (h > HUE_RED_LO && h <= HUE_GREEN_LO) off = 8'd0;
    else if (h > HUE_GREEN_LO && h <= HUE_BLUE_LO)    off = HUE_GREEN_LO;
    else                                              off = HUE_BLUE_LO;
    prod      = 10'(h - off) * 10'(HUE_SLOPE);
    wheel_lvl = ({2'b00, full_level_i} > prod) ? 8'(full_level_i - prod[7:0]) : 8'd0;
  end

  assign target  = palette_color(idx_q);
  assign step_r  = step_toward(red_q, target[23:16]);
  assign step_g  = step_toward(green_q, target[15:8]);
  assign step_b  = step_toward(blue_q, target[7:0]);
  assign idx_inc = {1'b0, idx_q} + {{PAL_IDX_W{1'b0}}, 1'b1};

  always_comb begin
    mode_d       = mode_q;
    red_d        = red_q;
    green_d      = green_q;
    blue_d       = blue_q;
    bright_d     = bright_q;
    idx_d        = idx_q;
    red_held_d   = red_held_q;
    party_held_d = party_held_q;
    red_on       = (mode_q == MODE_RED);
    party_on     = (mode_q == MODE_PARTY);
    if (fire_i) begin
      unique case (item_i.kind)
        KIND_KNOB: begin
          if (mode_q == MODE_KNOB) begin
            bright_d = item_i.brightness_sample;
            priority if (h > HUE_RED_LO && h <= HUE_GREEN_LO) begin
              red_d   = wheel_lvl;
              green_d = full_level_i - wheel_lvl;
              blue_d  = 8'd0;
            end else if (h > HUE_GREEN_LO && h <= HUE_BLUE_LO) begin
              green_d = wheel_lvl;
              blue_d  = full_level_i - wheel_lvl;
              red_d   = 8'd0;
            end else if (h > HUE_BLUE_LO && h <= HUE_RED_HI) begin
              blue_d  = wheel_lvl;
              red_d   = full_level_i - wheel_lvl;
              green_d = 8'd0;
            end else begin
              red_d   = full_level_i;
              green_d = 8'd0;
              blue_d  = 8'd0;
            end
          end
        end
        KIND_TICK: begin
          if (mode_q == MODE_PARTY) begin
            red_d   = step_r;
            green_d = step_g;
            blue_d  = step_b;
            if (step_r == target[23:16] && step_g == target[15:8] &&
                step_b == target[7:0]) begin
              idx_d = idx_inc[PAL_IDX_W-1:0];
              if ({1'b0, idx_inc[PAL_IDX_W-1:0]} >= (PAL_IDX_W+1)'(NUM_COLOURS)) begin
                idx_d = '0;
              end
            end
          end
        end
        KIND_BUTTON: begin
          if (item_i.red_button && !red_held_q) begin
            party_on   = 1'b0;
            red_on     = !red_on;
            red_held_d = 1'b1;
          end else begin
            red_held_d = 1'b0;
          end
          if (item_i.party_button && !party_held_q) begin
            red_on       = 1'b0;
            party_on     = !party_on;
            party_held_d = 1'b1;
          end else begin
            party_held_d = 1'b0;
          end
          mode_d = red_on ? MODE_RED : (party_on ? MODE_PARTY : MODE_KNOB);
          if (mode_d != mode_q) begin
            if (mode_d == MODE_RED) begin
              red_d    = full_level_i;
              green_d  = 8'd0;
              blue_d   = 8'd0;
              bright_d = 8'd0;
            end else if (mode_d == MODE_PARTY) begin
              red_d   = 8'd0;
              green_d = 8'd0;
              blue_d  = 8'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_KNOB;
      red_q        <= 8'd0;
      green_q      <= 8'd0;
      blue_q       <= 8'd0;
      bright_q     <= 8'd0;
      idx_q        <= '0;
      red_held_q   <= 1'b0;
      party_held_q <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      red_q        <= red_d;
      green_q      <= green_d;
      blue_q       <= blue_d;
      bright_q     <= bright_d;
      idx_q        <= idx_d;
      red_held_q   <= red_held_d;
      party_held_q <= party_held_d;
    end
  end

  assign result_o = '{red_duty: red_q, green_duty: green_q, blue_duty: blue_q,
                      brightness: bright_q, mode: mode_q};

endmodule

### src/rgb_lamp_mode_and_fade_controller.sv
// Top level of the RGB lamp mode and fade controller.
// One result beat per input beat, one beat per cycle sustained while the result
// is not stalled. A beat passes the input register, then the state and result
// register. The lamp state registers are the result register, so a stalled
// result holds the state and the input side takes one more beat before stalling.
// Kind 0 applies a knob sample in knob mode, kind 1 fades one step toward the
// current palette colour in party mode, kind 2 updates buttons and mode.
module rgb_lamp_mode_and_fade_controller import rlmf_pkg::*; #(
  parameter int unsigned NUM_COLOURS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] hue_sample_i,
  input  logic [7:0] brightness_sample_i,
  input  logic       red_button_i,
  input  logic       party_button_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_duty_o,
  output logic [7:0] green_duty_o,
  output logic [7:0] blue_duty_o,
  output logic [7:0] brightness_o,
  output logic [1:0] mode_o
);

  logic [7:0] full_level_q;
  logic       out_valid_q, out_valid_d;
  logic       s1_valid, out_free, fire;
  item_t      item_in, s1_item;
  result_t    result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_level_q <= FULL_LEVEL_RST;
    end else if (cfg_we_i) begin
      full_level_q <= cfg_wdata_i;
    end
  end

  assign item_in  = '{kind: kind_i, hue_sample: hue_sample_i,
                      brightness_sample: brightness_sample_i,
                      red_button: red_button_i, party_button: party_button_i};
  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = s1_valid && out_free;

  rlmf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .item_i     (item_in),
    .take_i     (fire),
    .in_stall_o (in_stall_o),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  rlmf_core #(
    .NUM_COLOURS (NUM_COLOURS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (s1_item),
    .full_level_i (full_level_q),
    .result_o     (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_duty_o   = result.red_duty;
  assign green_duty_o = result.green_duty;
  assign blue_duty_o  = result.blue_duty;
  assign brightness_o = result.brightness;
  assign mode_o       = result.mode;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid)
    else $error("input stalled with empty input stage");

  a_fire_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed beat not presented");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(mode_o) && $stable(red_duty_o) && $stable(brightness_o)))
    else $error("lamp state changed without a beat");

  a_red_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && mode_o != MODE_RED) |=> (mode_o != MODE_RED || brightness_o == 8'd0))
    else $error("red mode entered with nonzero brightness");

endmodule
